// File: hdl/pdps_pkg.sv
// Shared types, constants and command/status structs of the packet statistics core.
package pdps_pkg;

  // Default depth of the destination table.
  localparam int unsigned TableEntries = 16;

  // Payload widths.
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 224;

  // Lead word codes.
  localparam logic [31:0] OobWord = 32'hFFFF_FFFF;
  localparam logic [31:0] FragBit = 32'h8000_0000;

  // Shortest packet that is counted.
  localparam logic [15:0] MinLength = 16'd4;

  // Counters of one table entry.
  typedef struct packed {
    logic [31:0] oob;
    logic [31:0] frag_octets;
    logic [31:0] frags;
    logic [15:0] max_len;
    logic [31:0] bytes;
    logic [31:0] packets;
  } ctr_t;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StDumpScan,
    StDumpLoad
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch a record request and read its entry
    logic update;      // write back the counters of the latched request
    logic scan_start;  // restart the dump index
    logic scan_read;   // read the entry at the dump index
    logic scan_next;   // advance the dump index
    logic load_entry;  // place the entry just read into the output register
    logic load_empty;  // place the empty-table result into the output register
    logic clear;       // mark every entry free
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_dump;     // request at the input is a dump
    logic short_pkt;   // request at the input is shorter than the minimum
    logic can_record;  // destination hits or a free entry exists
    logic scan_end;    // dump index has passed the last entry
    logic scan_used;   // entry at the dump index is used
    logic more;        // a used entry lies above the dump index
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

endpackage

// File: hdl/pdps_ctrl.sv
// Controller state machine that sequences record updates and table dumps.
module pdps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  pdps_pkg::dp_status_t status_i,
  output pdps_pkg::dp_cmd_t    cmd_o
);
  import pdps_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          if (status_i.is_dump) begin
            state_d = StDumpScan;
          end else if (!status_i.short_pkt && status_i.can_record) begin
            state_d = StUpdate;
          end
        end
      end
      StUpdate: begin
        state_d = StIdle;
      end
      StDumpScan: begin
        if (status_i.scan_end) begin
          if (status_i.out_free) begin
            state_d = StIdle;
          end
        end else if (status_i.scan_used && status_i.out_free) begin
          state_d = StDumpLoad;
        end
      end
      StDumpLoad: begin
        state_d = status_i.more ? StDumpScan : StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      StIdle: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (status_i.is_dump) begin
            cmd_o.scan_start = 1'b1;
          end else if (!status_i.short_pkt && status_i.can_record) begin
            cmd_o.capture = 1'b1;
          end
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
      end
      StDumpScan: begin
        if (status_i.scan_end) begin
          if (status_i.out_free) begin
            cmd_o.load_empty = 1'b1;
            cmd_o.clear      = 1'b1;
          end
        end else if (status_i.scan_used) begin
          if (status_i.out_free) begin
            cmd_o.scan_read = 1'b1;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      StDumpLoad: begin
        cmd_o.load_entry = 1'b1;
        cmd_o.scan_next  = 1'b1;
        cmd_o.clear      = !status_i.more;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: hdl/pdps_datapath.sv
// Datapath: destination tags, counter memory, update arithmetic and output register.
module pdps_datapath #(
  parameter int unsigned TABLE_ENTRIES = pdps_pkg::TableEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pdps_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [pdps_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tuser_o,
  output logic                          m_axis_tlast_o,
  input  pdps_pkg::dp_cmd_t             cmd_i,
  output pdps_pkg::dp_status_t          status_o
);
  import pdps_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CtrW = $bits(ctr_t);

  // Unpacked input fields.
  logic [31:0] in_ip;
  logic [15:0] in_port;
  logic [15:0] in_len;
  logic [31:0] in_lead;
  assign in_ip   = s_axis_tdata_i[31:0];
  assign in_port = s_axis_tdata_i[47:32];
  assign in_len  = s_axis_tdata_i[63:48];
  assign in_lead = s_axis_tdata_i[95:64];

  // Table state.
  logic [TABLE_ENTRIES-1:0] used_q;
  logic [31:0]              tag_ip_q   [TABLE_ENTRIES];
  logic [15:0]              tag_port_q [TABLE_ENTRIES];
  logic [CtrW-1:0]          mem_q      [TABLE_ENTRIES];
  logic [CtrW-1:0]          rd_data_q;

  // Latched record request.
  logic [31:0]     item_ip_q;
  logic [15:0]     item_port_q;
  logic [15:0]     item_len_q;
  logic [31:0]     item_lead_q;
  logic [IdxW-1:0] slot_q;
  logic            hit_q;

  // Dump index, wide enough to count up to TABLE_ENTRIES so it can reach the end.
  logic [CntW-1:0] idx_q;
  logic [IdxW-1:0] idx;
  assign idx = idx_q[IdxW-1:0];

  // Output register.
  logic            out_valid_q;
  logic            out_entry_q;
  logic            out_last_q;
  logic [31:0]     out_ip_q;
  logic [15:0]     out_port_q;
  ctr_t            out_ctr_q;

  // Parallel tag match and lowest free entry.
  logic [TABLE_ENTRIES-1:0] match;
  logic                     hit_any;
  logic                     free_any;
  logic [IdxW-1:0]          hit_idx;
  logic [IdxW-1:0]          free_idx;
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      match[k] = used_q[k] && (tag_ip_q[k] == in_ip) && (tag_port_q[k] == in_port);
    end
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_any = 1'b1;
        hit_idx = IdxW'(k);
      end
      if (!used_q[k]) begin
        free_any = 1'b1;
        free_idx = IdxW'(k);
      end
    end
  end

  // Used entries above the dump index.
  logic more_above;
  always_comb begin
    more_above = 1'b0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if ((CntW'(k) > idx_q) && used_q[k]) begin
        more_above = 1'b1;
      end
    end
  end

  assign status_o.is_dump    = s_axis_tuser_i;
  assign status_o.short_pkt  = (in_len < MinLength);
  assign status_o.can_record = hit_any || free_any;
  assign status_o.scan_end   = (idx_q >= CntW'(TABLE_ENTRIES));
  assign status_o.scan_used  = used_q[idx];
  assign status_o.more       = more_above;
  assign status_o.out_free   = !out_valid_q || m_axis_tready_i;

  // Counter update: a fresh entry starts from zero.
  ctr_t base;
  ctr_t upd;
  logic is_oob;
  logic is_frag;
  always_comb begin
    base    = hit_q ? ctr_t'(rd_data_q) : '0;
    is_oob  = (item_lead_q == OobWord);
    is_frag = ((item_lead_q & FragBit) != 32'd0) && !is_oob;
    upd            = base;
    upd.packets    = base.packets + 32'd1;
    upd.bytes      = base.bytes + {16'd0, item_len_q};
    upd.max_len    = (item_len_q > base.max_len) ? item_len_q : base.max_len;
    if (is_oob) begin
      upd.oob = base.oob + 32'd1;
    end
    if (is_frag) begin
      upd.frags       = base.frags + 32'd1;
      upd.frag_octets = base.frag_octets + {16'd0, item_len_q};
    end
  end

  // Counter memory with registered read.
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  assign rd_en   = cmd_i.capture || cmd_i.scan_read;
  assign rd_addr = cmd_i.capture ? (hit_any ? hit_idx : free_idx) : idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem_q[slot_q] <= CtrW'(upd);
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Tags are written when an entry is allocated.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && !hit_q) begin
      tag_ip_q[slot_q]   <= item_ip_q;
      tag_port_q[slot_q] <= item_port_q;
    end
  end

  // Latched record request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_ip_q   <= in_ip;
      item_port_q <= in_port;
      item_len_q  <= in_len;
      item_lead_q <= in_lead;
      slot_q      <= hit_any ? hit_idx : free_idx;
      hit_q       <= hit_any;
    end
  end

  // Used flags and dump index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        used_q <= '0;
      end else if (cmd_i.update) begin
        used_q[slot_q] <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        idx_q <= '0;
      end else if (cmd_i.scan_next) begin
        idx_q <= idx_q + CntW'(1);
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_entry || cmd_i.load_empty) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_entry) begin
      out_entry_q <= 1'b1;
      out_last_q  <= !more_above;
      out_ip_q    <= tag_ip_q[idx];
      out_port_q  <= tag_port_q[idx];
      out_ctr_q   <= ctr_t'(rd_data_q);
    end else if (cmd_i.load_empty) begin
      out_entry_q <= 1'b0;
      out_last_q  <= 1'b1;
      out_ip_q    <= '0;
      out_port_q  <= '0;
      out_ctr_q   <= '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_entry_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {out_ctr_q.oob, out_ctr_q.frag_octets, out_ctr_q.frags,
                            out_ctr_q.max_len, out_ctr_q.bytes, out_ctr_q.packets,
                            out_port_q, out_ip_q};

endmodule

// File: hdl/per_destination_packet_stats_core.sv
// Top level of the per-destination packet statistics core.
//
//   Channel  Dir  tdata (lowest bit up)                          tuser        tlast
//   s_axis   in   dest_ip, dest_port, pkt_length, lead_word      command      -
//   m_axis   out  out_ip, out_port, packet_count, byte_count,    entry_valid  last
//                 max_length, fragment_count, fragment_bytes,
//                 oob_count
//
// A record request matches the destination against all tags and reads the entry's
// counters in the accept cycle, and writes them back in the next cycle. A short
// packet or a packet dropped on a full table is accepted without any write-back.
// A dump steps through the entries up to the last used one, reading each used entry
// into the output register; an empty table yields one empty result at the scan's end.
// Reset frees every entry at once. A stalled output holds the dump until taken.
module per_destination_packet_stats_core #(
  parameter int unsigned TABLE_ENTRIES = pdps_pkg::TableEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // dest_ip[31:0], dest_port[47:32], pkt_length[63:48], lead_word[95:64]
  input  logic [pdps_pkg::InDataW-1:0]  s_axis_tdata_i,
  // command[0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_ip[31:0], out_port[47:32], packet_count[79:48], byte_count[111:80],
  // max_length[127:112], fragment_count[159:128], fragment_bytes[191:160],
  // oob_count[223:192]
  output logic [pdps_pkg::OutDataW-1:0] m_axis_tdata_o,
  // entry_valid[0]
  output logic                          m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import pdps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  pdps_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  // Table and counters.
  pdps_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule
